### design/ule_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ule_pkg;

  // Result kinds as they leave on tuser.
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_BS   = 8'h08;
  localparam logic [7:0] CHAR_DEL  = 8'h7F;
  localparam logic [7:0] CHAR_BEL  = 8'h07;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_CODE = 8'h80;

  typedef logic [3:0] step_t;

  // Class of the received byte, used by the dispatch jump.
  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_LF    = 2'd1,
    CLS_ERASE = 2'd2,
    CLS_PRINT = 2'd3
  } cls_e;

  // Source of an emitted result.
  typedef enum logic [2:0] {
    SRC_RAM  = 3'd0,
    SRC_BYTE = 3'd1,
    SRC_BEL  = 3'd2,
    SRC_BS   = 3'd3,
    SRC_SP   = 3'd4,
    SRC_END  = 3'd5
  } src_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e;

  typedef enum logic [2:0] {
    IDX_HOLD   = 3'd0,
    IDX_CLR    = 3'd1,
    IDX_INC    = 3'd2,
    IDX_CNT_M1 = 3'd3,
    IDX_DEC    = 3'd4
  } idx_op_e;

  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NOT_ACC  = 3'd2,
    COND_DISPATCH = 3'd3,
    COND_CNT_ZERO = 3'd4,
    COND_MORE     = 3'd5,
    COND_NOT_CONT = 3'd6,
    COND_FULL     = 3'd7
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    logic    take;
    logic    emit;
    src_e    src;
    logic    last;
    cnt_op_e cnt_op;
    idx_op_e idx_op;
    logic    wr;
    cond_e   cond;
    step_t   target;
  } ctrl_t;

  // Status flags the datapath hands to the sequencer.
  typedef struct packed {
    logic stall;
    logic in_valid;
    cls_e cls;
    logic cnt_zero;
    logic more;
    logic cont;
    logic full;
  } flags_t;

endpackage

`default_nettype wire

### design/ule_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ule_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### design/ule_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module ule_seq
  import ule_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire flags_t flags_i,
  output ctrl_t       ctrl_o
);

  localparam step_t StWait  = 4'd0;
  localparam step_t StDisp  = 4'd1;
  localparam step_t StLf0   = 4'd2;
  localparam step_t StLf1   = 4'd3;
  localparam step_t StLfEnd = 4'd4;
  localparam step_t StEr0   = 4'd5;
  localparam step_t StEr1   = 4'd6;
  localparam step_t StEr2   = 4'd7;
  localparam step_t StEr3   = 4'd8;
  localparam step_t StEr4   = 4'd9;
  localparam step_t StEr5   = 4'd10;
  localparam step_t StBell  = 4'd11;
  localparam step_t StPr0   = 4'd12;
  localparam step_t StPr1   = 4'd13;

  function automatic ctrl_t prog(input step_t s);
    ctrl_t w;
    w = '0;
    unique case (s)
      StWait: begin
        w.take = 1'b1; w.cond = COND_NOT_ACC; w.target = StWait;
      end
      StDisp: begin
        w.cond = COND_DISPATCH;
      end
      StLf0: begin
        w.idx_op = IDX_CLR; w.cond = COND_CNT_ZERO; w.target = StLfEnd;
      end
      StLf1: begin
        w.emit = 1'b1; w.src = SRC_RAM; w.idx_op = IDX_INC;
        w.cond = COND_MORE; w.target = StLf1;
      end
      StLfEnd: begin
        w.emit = 1'b1; w.src = SRC_END; w.last = 1'b1; w.cnt_op = CNT_CLR;
        w.cond = COND_ALWAYS; w.target = StWait;
      end
      StEr0: begin
        w.cond = COND_CNT_ZERO; w.target = StBell;
      end
      StEr1: begin
        w.emit = 1'b1; w.src = SRC_BS;
      end
      StEr2: begin
        w.emit = 1'b1; w.src = SRC_SP;
      end
      StEr3: begin
        w.emit = 1'b1; w.src = SRC_BS; w.last = 1'b1;
        w.cnt_op = CNT_DEC; w.idx_op = IDX_CNT_M1;
      end
      StEr4: begin
        w.cond = COND_NOT_CONT; w.target = StWait;
      end
      StEr5: begin
        w.cnt_op = CNT_DEC; w.idx_op = IDX_DEC;
        w.cond = COND_ALWAYS; w.target = StEr4;
      end
      StBell: begin
        w.emit = 1'b1; w.src = SRC_BEL; w.last = 1'b1;
        w.cond = COND_ALWAYS; w.target = StWait;
      end
      StPr0: begin
        w.cond = COND_FULL; w.target = StBell;
      end
      StPr1: begin
        w.emit = 1'b1; w.src = SRC_BYTE; w.last = 1'b1; w.wr = 1'b1;
        w.cnt_op = CNT_INC; w.cond = COND_ALWAYS; w.target = StWait;
      end
      default: begin
        w.cond = COND_ALWAYS; w.target = StWait;
      end
    endcase
    return w;
  endfunction

  step_t upc_q, upc_d;
  step_t disp_tgt;
  logic  branch;

  assign ctrl_o = prog(upc_q);

  always_comb begin
    unique case (flags_i.cls)
      CLS_LF:    disp_tgt = StLf0;
      CLS_ERASE: disp_tgt = StEr0;
      CLS_PRINT: disp_tgt = StPr0;
      default:   disp_tgt = StWait;
    endcase
  end

  always_comb begin
    unique case (ctrl_o.cond)
      COND_NEXT:     branch = 1'b0;
      COND_ALWAYS:   branch = 1'b1;
      COND_NOT_ACC:  branch = ~flags_i.in_valid;
      COND_DISPATCH: branch = 1'b1;
      COND_CNT_ZERO: branch = flags_i.cnt_zero;
      COND_MORE:     branch = flags_i.more;
      COND_NOT_CONT: branch = ~flags_i.cont;
      COND_FULL:     branch = flags_i.full;
      default:       branch = 1'b0;
    endcase
  end

  always_comb begin
    if (flags_i.stall) begin
      upc_d = upc_q;
    end else if (branch) begin
      upc_d = (ctrl_o.cond == COND_DISPATCH) ? disp_tgt : ctrl_o.target;
    end else begin
      upc_d = upc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= StWait;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

### design/utf8_line_editor.sv
`timescale 1ns / 1ps
`default_nettype none
// Terminal line editor with UTF-8 aware erase.
// The s_axis channel takes one received byte per item in tdata. The m_axis
// channel returns result items: tuser carries the kind (echo, line byte or
// line end), tdata carries the byte and the line length, and tlast marks the
// final result caused by one received byte. Control bytes other than line
// feed, carriage return, backspace and DEL produce no result at all.
// Items are handled one at a time by a small microprogram. A printable byte
// is echoed and stored, or rings the bell on a full line; an erase sends
// backspace, space, backspace and removes the last byte and the rest of its
// UTF-8 sequence, or rings the bell on an empty line; a line end walks the
// stored bytes, then sends the line end. The line walk reads one stored byte
// per cycle from the single-read line RAM while the receiver does not stall.
// A new byte is accepted only in the wait step of the program.
// Results sit in one output register; while the receiver holds tready low the
// program stalls on its next result step and nothing is lost. Reset empties
// the line and the output register and returns the program to its wait step;
// the line RAM itself is not cleared, since only written entries are read.
module utf8_line_editor
  import ule_pkg::*;
#(
  parameter int LINE_BUFFER_BYTES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [7:0] out_byte, [12:8] line_length, zero pad
  output logic      [1:0]  m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // last
);

  localparam int CntW = $clog2(LINE_BUFFER_BYTES);

  ctrl_t  ctrl;
  flags_t flags;

  logic [7:0]      byte_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [7:0]      rd_data;
  logic            stall;
  logic            adv;
  logic            load_out;
  cls_e            cls;

  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_kind_q;
  logic [7:0]      out_byte_q;
  logic [4:0]      out_len_q;
  logic            out_last_q;

  logic [1:0]      res_kind;
  logic [7:0]      res_byte;
  logic [4:0]      res_len;
  logic [CntW+4:0] cnt_ext;

  ule_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl)
  );

  ule_ram #(
    .WIDTH(8),
    .DEPTH(LINE_BUFFER_BYTES)
  ) u_line_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ctrl.wr & adv),
    .wr_addr_i(cnt_q),
    .wr_data_i(byte_q),
    .rd_en_i  (adv),
    .rd_addr_i(idx_d),
    .rd_data_o(rd_data)
  );

  // A result step waits while the output register is full and not being taken.
  assign stall         = ctrl.emit & out_valid_q & ~m_axis_tready;
  assign adv           = ~stall;
  assign load_out      = ctrl.emit & adv;
  assign s_axis_tready = ctrl.take;

  always_comb begin
    unique case (byte_q) inside
      CHAR_LF, CHAR_CR:   cls = CLS_LF;
      CHAR_BS, CHAR_DEL:  cls = CLS_ERASE;
      default:            cls = (byte_q >= CHAR_SP) ? CLS_PRINT : CLS_OTHER;
    endcase
  end

  assign flags.stall    = stall;
  assign flags.in_valid = s_axis_tvalid;
  assign flags.cls      = cls;
  assign flags.cnt_zero = (cnt_q == '0);
  assign flags.more     = (({1'b0, idx_q} + (CntW+1)'(1)) != {1'b0, cnt_q});
  // The erase walk goes on only while bytes remain and the byte just dropped
  // is a UTF-8 continuation byte.
  assign flags.cont     = (cnt_q != '0) && ((rd_data & CONT_MASK) == CONT_CODE);
  assign flags.full     = (cnt_q == CntW'(LINE_BUFFER_BYTES - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (adv) begin
      unique case (ctrl.cnt_op)
        CNT_INC:  cnt_d = cnt_q + CntW'(1);
        CNT_DEC:  cnt_d = cnt_q - CntW'(1);
        CNT_CLR:  cnt_d = '0;
        default:  cnt_d = cnt_q;
      endcase
    end
  end

  // The RAM is read at the next index, so during the line and erase walks its
  // output shows the entry at the current one.
  always_comb begin
    idx_d = idx_q;
    if (adv) begin
      unique case (ctrl.idx_op)
        IDX_CLR:    idx_d = '0;
        IDX_INC:    idx_d = idx_q + CntW'(1);
        IDX_CNT_M1: idx_d = cnt_q - CntW'(1);
        IDX_DEC:    idx_d = idx_q - CntW'(1);
        default:    idx_d = idx_q;
      endcase
    end
  end

  assign cnt_ext = {5'b0, cnt_q};

  always_comb begin
    res_kind = KIND_ECHO;
    res_byte = '0;
    res_len  = '0;
    unique case (ctrl.src)
      SRC_RAM: begin
        res_kind = KIND_LINE;
        res_byte = rd_data;
      end
      SRC_BYTE: res_byte = byte_q;
      SRC_BEL:  res_byte = CHAR_BEL;
      SRC_BS:   res_byte = CHAR_BS;
      SRC_SP:   res_byte = CHAR_SP;
      SRC_END: begin
        res_kind = KIND_END;
        res_len  = cnt_ext[4:0];
      end
      default:  res_byte = '0;
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && ctrl.take) begin
      byte_q <= s_axis_tdata;
    end
    if (load_out) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_len_q  <= res_len;
      out_last_q <= ctrl.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_len_q, out_byte_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### design/ule_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module ule_chk
  import ule_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A line end always closes the results of its byte.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_END) |-> m_axis_tlast)
    else $error("line end without tlast");

  // Line bytes are never final and carry no length.
  a_line_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_LINE) |->
      !m_axis_tlast && (m_axis_tdata[12:8] == 5'd0))
    else $error("line byte with tlast or length");

  // Echo results carry no length.
  a_echo_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_ECHO) |-> (m_axis_tdata[12:8] == 5'd0))
    else $error("echo with length");

  // One byte at a time: right after an accept the input side is closed.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind utf8_line_editor ule_chk u_ule_chk (.*);

`default_nettype wire

### bench/utf8_line_editor_tb.sv
`timescale 1ns / 1ps

module utf8_line_editor_tb;
  import ule_pkg::*;

  localparam int LINE_BYTES = 32;
  // A hung block ends the run here. The worst correct run is roughly 500 items
  // of 32 results each, every result held off by the longest receiver stall.
  localparam int CYCLE_LIMIT = 4_000_000;
  // This covers any result that is still on its way, such as the results of
  // a line end of a full line.
  localparam int SETTLE_CYCLES = 80;
  localparam int PRINT_CAP = 20;

  // One result item as the editor hands it out.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [4:0] len;
    logic       last;
  } editor_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [12:8] line_length, zero pad
  logic [1:0]  m_axis_tuser;           // [1:0] kind
  logic        m_axis_tlast;

  // Shadow copy of the editor's line, kept by the predictor.
  logic [7:0]  shadow_line [LINE_BYTES];
  int          shadow_fill = 0;

  editor_result_t expected_results[$];
  editor_result_t oldest;
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    active_items = 0;    // accepted bytes that cause results
  bit             allow_idle = 1'b1;   // both sides may insert gaps
  int             ready_hold = 0;

  utf8_line_editor #(
    .LINE_BUFFER_BYTES(LINE_BYTES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("utf8_line_editor: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Most gaps are zero or a few cycles; now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (!allow_idle) begin
      return 0;
    end
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return $urandom_range(20, 60);
    end else if (roll < 6) begin
      return $urandom_range(1, 3);
    end
    return 0;
  endfunction

  function automatic editor_result_t make_result(input logic [1:0] kind,
                                                 input logic [7:0] data,
                                                 input int len);
    editor_result_t r;
    r.kind = kind;
    r.data = data;
    r.len  = 5'(len);
    r.last = 1'b0;
    return r;
  endfunction

  // Control bytes other than line feed, carriage return, backspace and DEL are
  // dropped by the editor without any result.
  function automatic bit is_ignored(input logic [7:0] rx);
    return rx < CHAR_SP && rx != CHAR_LF && rx != CHAR_CR && rx != CHAR_BS;
  endfunction

  // Works out what the editor answers to one received byte and updates the
  // shadow line. The final result of the batch carries the last flag.
  task automatic predict_editor(input logic [7:0] rx);
    editor_result_t batch[$];
    logic [7:0]     ch;
    ch = (rx == CHAR_CR) ? CHAR_LF : rx;
    if (ch == CHAR_LF) begin
      for (int i = 0; i < shadow_fill; i++) begin
        batch.push_back(make_result(KIND_LINE, shadow_line[i], 0));
      end
      batch.push_back(make_result(KIND_END, 8'h00, shadow_fill));
      shadow_fill = 0;
    end else if (ch == CHAR_BS || ch == CHAR_DEL) begin
      if (shadow_fill == 0) begin
        batch.push_back(make_result(KIND_ECHO, CHAR_BEL, 0));
      end else begin
        batch.push_back(make_result(KIND_ECHO, CHAR_BS, 0));
        batch.push_back(make_result(KIND_ECHO, CHAR_SP, 0));
        batch.push_back(make_result(KIND_ECHO, CHAR_BS, 0));
        // Drop the last byte, then keep dropping while the byte just removed
        // was a continuation byte, so the lead byte goes with its sequence.
        shadow_fill--;
        while (shadow_fill > 0 &&
               (shadow_line[shadow_fill] & CONT_MASK) == CONT_CODE) begin
          shadow_fill--;
        end
      end
    end else if (ch >= CHAR_SP) begin
      if (shadow_fill >= LINE_BYTES - 1) begin
        batch.push_back(make_result(KIND_ECHO, CHAR_BEL, 0));
      end else begin
        batch.push_back(make_result(KIND_ECHO, ch, 0));
        shadow_line[shadow_fill] = ch;
        shadow_fill++;
      end
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    foreach (batch[i]) begin
      expected_results.push_back(batch[i]);
    end
  endtask

  // Sends one byte. Valid is only lowered when a gap is wanted, so a byte
  // that follows at once keeps valid high without a glitch.
  task automatic send_byte(input logic [7:0] rx);
    int gap;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= rx;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    predict_editor(rx);
    if (!is_ignored(rx)) begin
      active_items++;
    end
  endtask

  // Holds the sender off until every expected result has come out.
  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Receiver side: stalls of random length, decided at the falling edge.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      m_axis_tready <= 1'b0;
    end else if (allow_idle && $urandom_range(0, 3) == 0) begin
      ready_hold = pick_gap();
      m_axis_tready <= (ready_hold == 0);
      if (ready_hold > 0) begin
        ready_hold--;
      end
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: kind %0d byte %02h len %0d",
                                  m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[12:8]));
      end else begin
        oldest = expected_results.pop_front();
        if (m_axis_tuser !== oldest.kind) begin
          report_mismatch($sformatf("kind %0d, expected %0d", m_axis_tuser, oldest.kind));
        end
        if (m_axis_tdata[7:0] !== oldest.data) begin
          report_mismatch($sformatf("out_byte %02h, expected %02h",
                                    m_axis_tdata[7:0], oldest.data));
        end
        if (m_axis_tdata[12:8] !== oldest.len) begin
          report_mismatch($sformatf("line_length %0d, expected %0d",
                                    m_axis_tdata[12:8], oldest.len));
        end
        if (m_axis_tlast !== oldest.last) begin
          report_mismatch($sformatf("tlast %0b, expected %0b", m_axis_tlast, oldest.last));
        end
      end
    end
  end

  // Line ends on an empty line: carriage return must act as line feed.
  task automatic test_empty_line_end();
    send_byte(CHAR_LF);
    send_byte(CHAR_CR);
  endtask

  // Both erase codes on an empty line ring the bell.
  task automatic test_erase_on_empty();
    send_byte(CHAR_BS);
    send_byte(CHAR_DEL);
  endtask

  // Control bytes outside the handled set give nothing at all.
  task automatic test_ignored_controls();
    send_byte(8'h00);
    send_byte(8'h1F);
    send_byte(CHAR_BEL);
    send_byte(8'h09);
  endtask

  // Lowest and highest printable bytes, stored and handed on as a line.
  task automatic test_printable_extremes();
    send_byte(CHAR_SP);
    send_byte(8'h7E);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
  endtask

  // A three byte sequence goes in one erase; a run of stray continuation
  // bytes is erased back to the start of the line.
  task automatic test_utf8_erase();
    send_byte(8'hE2);
    send_byte(8'h82);
    send_byte(8'hAC);
    send_byte(8'h61);
    send_byte(CHAR_DEL);
    send_byte(CHAR_BS);
    send_byte(CHAR_LF);
    send_byte(8'h80);
    send_byte(8'hBF);
    send_byte(CHAR_BS);
    send_byte(CHAR_LF);
  endtask

  // Fills the line to capacity with random printable bytes, then checks the
  // bell on a full line and either the longest line end or one erase and a line end.
  task automatic test_full_line();
    logic [7:0] ch;
    while (shadow_fill < LINE_BYTES - 1) begin
      ch = 8'($urandom_range(8'h20, 8'hFF));
      send_byte((ch == CHAR_DEL) ? 8'h7E : ch);
    end
    send_byte(8'h41);
    send_byte(8'hF0);
    if ($urandom_range(0, 1) == 1) begin
      send_byte(CHAR_LF);
    end else begin
      send_byte(CHAR_DEL);
      send_byte(CHAR_CR);
    end
  endtask

  // One UTF-8 sequence of random length: a lead byte and as many continuation bytes as it calls for.
  task automatic send_utf8_char();
    int roll;
    int tail;
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      send_byte(8'($urandom_range(8'h20, 8'h7E)));
      tail = 0;
    end else if (roll < 7) begin
      send_byte(8'($urandom_range(8'hC2, 8'hDF)));
      tail = 1;
    end else if (roll < 9) begin
      send_byte(8'($urandom_range(8'hE0, 8'hEF)));
      tail = 2;
    end else begin
      send_byte(8'($urandom_range(8'hF0, 8'hF4)));
      tail = 3;
    end
    repeat (tail) send_byte(8'($urandom_range(8'h80, 8'hBF)));
  endtask

  // Mostly typing of valid characters with erases and line ends, mixed with
  // raw noise, stray continuation bytes and broken sequences.
  task automatic test_random_traffic(input int target);
    int unsigned start_items;
    int          round;
    int          roll;
    logic [7:0]  ch;
    start_items = active_items;
    round = 0;
    while (active_items - start_items < target) begin
      // Idling comes and goes in stretches.
      if (round % 40 == 0) begin
        allow_idle = ($urandom_range(0, 3) != 0);
      end
      if (round == 90) begin
        wait_for_results();
      end
      if (round == 60 || round == 200) begin
        test_full_line();
      end
      roll = $urandom_range(0, 99);
      if (shadow_fill > 24 && roll < 40) begin
        send_byte(($urandom_range(0, 1) == 1) ? CHAR_LF : CHAR_CR);
      end else if (roll < 50) begin
        send_utf8_char();
      end else if (roll < 62) begin
        send_byte(($urandom_range(0, 1) == 1) ? CHAR_BS : CHAR_DEL);
      end else if (roll < 72) begin
        send_byte(($urandom_range(0, 1) == 1) ? CHAR_LF : CHAR_CR);
      end else if (roll < 80) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (roll < 86) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      end else if (roll < 92) begin
        ch = 8'($urandom_range(8'h00, 8'h1F));
        send_byte(is_ignored(ch) ? ch : 8'h1B);
      end else if (roll < 96) begin
        repeat ($urandom_range(2, 5)) send_byte(CHAR_DEL);
      end else begin
        // Lead byte whose continuation bytes never come.
        send_byte(8'($urandom_range(8'hC2, 8'hF4)));
        send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      round++;
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_line_end();
    test_erase_on_empty();
    test_ignored_controls();
    test_printable_extremes();
    test_utf8_erase();
    wait_for_results();

    test_random_traffic(380);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never came", expected_results.size()));
    end

    if (mismatch_count == 0) begin
      $display("utf8_line_editor: match");
    end else begin
      $display("utf8_line_editor: mismatch");
    end
    $finish;
  end

endmodule
